// ===== design/stli_pkg.sv =====
// Package: transaction types, state codes and register map for the interpolator.
package stli_pkg;

  typedef struct packed {
    logic               command;
    logic [9:0]         entry_index;
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic               last_query;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               covered;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_X0,
    S_XN,
    S_WALK,
    S_LO,
    S_GO,
    S_WAIT
  } state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL_HI,
    MD_DIV
  } md_state_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0]  REG_POINTS_ADDR  = 2'd0;
  localparam logic [10:0] POINTS_RESET     = 11'd2;
  localparam int          DIV_STEPS        = 66;

endpackage

// ===== design/stli_muldiv.sv =====
// Multi-cycle |a|*|b|/|d| unit: two partial products, then restoring division.
module stli_muldiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [32:0] a,
  input  logic [32:0] b,
  input  logic [32:0] d,
  output logic        done,
  output logic [65:0] q
);

  stli_pkg::md_state_t state_r, state_nxt;
  logic [32:0] a_r;
  logic [15:0] bh_r;
  logic [32:0] d_r;
  logic [49:0] prod_r;
  logic [65:0] dq_r, dq_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [33:0] cand;
  logic        ge;

  assign cand = {rem_r, dq_r[65]};
  assign ge   = cand >= {1'b0, d_r};

  always_comb begin
    state_nxt = state_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      stli_pkg::MD_IDLE: begin
        if (go) state_nxt = stli_pkg::MD_MUL_HI;
      end
      stli_pkg::MD_MUL_HI: begin
        dq_nxt    = {16'b0, prod_r} + ({17'b0, 49'(a_r) * 49'(bh_r)} << 17);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = stli_pkg::MD_DIV;
      end
      stli_pkg::MD_DIV: begin
        rem_nxt = ge ? 33'(cand - {1'b0, d_r}) : cand[32:0];
        dq_nxt  = {dq_r[64:0], ge};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(stli_pkg::DIV_STEPS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = stli_pkg::MD_IDLE;
        end
      end
      default: state_nxt = stli_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stli_pkg::MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == stli_pkg::MD_IDLE && go) begin
      a_r    <= a;
      bh_r   <= b[32:17];
      d_r    <= d;
      prod_r <= a * b[16:0];
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign q    = dq_r;

endmodule

// ===== design/sorted_table_linear_interpolator.sv =====
// Sorted-table linear interpolator: a load writes one table entry; a query reads the first
// and last table x, walks the pointer through the table memory one step at a time, and when
// interpolating sets up the operands and runs the multiply/divide unit (a product step, then
// 66 quotient bits at one per cycle). One item at a time; busy is high while a query is in
// work. The result strobe is registered, rises as busy falls, and cannot be stalled.
// Synchronous active-low reset clears the pointer, control and points_in_use (to 2);
// table memory contents are undefined until loaded.
module sorted_table_linear_interpolator #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  stli_pkg::in_t  in_data,
  output logic           out_valid,
  output stli_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  stli_pkg::state_t state_r, state_nxt;
  logic [10:0]        points_r;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [AW-1:0]      j_r, j_nxt;
  logic signed [31:0] qx_r, qx_nxt;
  logic               last_r, last_nxt;
  logic signed [31:0] tx0_r, tx0_nxt, txl_r, txl_nxt;
  logic signed [31:0] x1_r, x1_nxt, y1_r, y1_nxt, y0_r, y0_nxt;
  logic signed [32:0] dy_r, dy_nxt, t_r, t_nxt, dx_r, dx_nxt;
  logic               out_valid_r, out_valid_nxt;
  stli_pkg::out_t     out_r, out_nxt;

  logic [63:0]   mem [TABLE_DEPTH];
  logic [63:0]   rdata_r;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;

  logic [16:0]   n_clamp;
  logic [AW-1:0] nm1;
  logic [AW-1:0] j_start;
  logic signed [31:0] rd_x, rd_y;
  logic          cov;
  logic          md_go, md_done;
  logic [65:0]   md_q;
  logic [32:0]   q_sat;
  logic          neg;
  logic signed [34:0] r_full;
  logic          accept;

  assign accept = start && (state_r == stli_pkg::S_IDLE);
  assign busy   = state_r != stli_pkg::S_IDLE;
  assign pready = 1'b1;
  assign prdata = {21'b0, points_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= stli_pkg::POINTS_RESET;
    end else if (psel && penable && pwrite && paddr == stli_pkg::REG_POINTS_ADDR) begin
      points_r <= pwdata[10:0];
    end
  end

  always_comb begin
    if (points_r < 11'd2) begin
      n_clamp = 17'd2;
    end else if ({6'b0, points_r} > 17'(TABLE_DEPTH)) begin
      n_clamp = 17'(TABLE_DEPTH);
    end else begin
      n_clamp = {6'b0, points_r};
    end
  end
  assign nm1     = AW'(n_clamp - 17'd1);
  assign j_start = (ptr_r > nm1) ? nm1 : ptr_r;
  assign rd_x    = rdata_r[63:32];
  assign rd_y    = rdata_r[31:0];
  assign cov     = (qx_r >= tx0_r) && (qx_r <= txl_r);

  assign we    = accept && in_data.command == stli_pkg::CMD_LOAD
                 && {7'b0, in_data.entry_index} < 17'(TABLE_DEPTH);
  assign waddr = AW'(in_data.entry_index);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {in_data.sample_x, in_data.sample_y};
    rdata_r <= mem[raddr];
  end

  stli_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (md_go),
    .a     (dy_r[32] ? 33'(-dy_r) : dy_r),
    .b     (t_r[32] ? 33'(-t_r) : t_r),
    .d     (dx_r[32] ? 33'(-dx_r) : dx_r),
    .done  (md_done),
    .q     (md_q)
  );

  // quotient beyond 33 bits saturates the sum anyway
  assign q_sat  = (md_q[65:33] != '0) ? {1'b1, 32'b0} : md_q[32:0];
  assign neg    = dy_r[32] ^ t_r[32] ^ dx_r[32];
  assign r_full = neg ? 35'(y0_r) - 35'(signed'({2'b0, q_sat}))
                      : 35'(y0_r) + 35'(signed'({2'b0, q_sat}));

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    j_nxt         = j_r;
    qx_nxt        = qx_r;
    last_nxt      = last_r;
    tx0_nxt       = tx0_r;
    txl_nxt       = txl_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    y0_nxt        = y0_r;
    dy_nxt        = dy_r;
    t_nxt         = t_r;
    dx_nxt        = dx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    raddr         = '0;
    md_go         = 1'b0;
    unique case (state_r)
      stli_pkg::S_IDLE: begin
        if (accept && in_data.command == stli_pkg::CMD_QUERY) begin
          qx_nxt    = in_data.sample_x;
          last_nxt  = in_data.last_query;
          state_nxt = stli_pkg::S_X0;
        end
      end
      stli_pkg::S_X0: begin
        tx0_nxt   = rd_x;
        raddr     = nm1;
        state_nxt = stli_pkg::S_XN;
      end
      stli_pkg::S_XN: begin
        txl_nxt   = rd_x;
        raddr     = j_start;
        j_nxt     = j_start;
        state_nxt = stli_pkg::S_WALK;
      end
      stli_pkg::S_WALK: begin
        if (j_r < nm1 && qx_r > rd_x) begin
          j_nxt = j_r + AW'(1);
          raddr = j_r + AW'(1);
        end else begin
          ptr_nxt = last_r ? '0 : j_r;
          x1_nxt  = rd_x;
          y1_nxt  = rd_y;
          if (!cov) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{value: '0, covered: 1'b0};
            state_nxt     = stli_pkg::S_IDLE;
          end else if (qx_r == rd_x || j_r == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{value: rd_y, covered: 1'b1};
            state_nxt     = stli_pkg::S_IDLE;
          end else begin
            raddr     = j_r - AW'(1);
            state_nxt = stli_pkg::S_LO;
          end
        end
      end
      stli_pkg::S_LO: begin
        y0_nxt    = rd_y;
        dy_nxt    = 33'(y1_r) - 33'(rd_y);
        t_nxt     = 33'(qx_r) - 33'(rd_x);
        dx_nxt    = 33'(x1_r) - 33'(rd_x);
        state_nxt = stli_pkg::S_GO;
      end
      stli_pkg::S_GO: begin
        if (dx_r == '0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{value: y0_r, covered: 1'b1};
          state_nxt     = stli_pkg::S_IDLE;
        end else begin
          md_go     = 1'b1;
          state_nxt = stli_pkg::S_WAIT;
        end
      end
      stli_pkg::S_WAIT: begin
        if (md_done) begin
          out_valid_nxt = 1'b1;
          out_nxt.covered = 1'b1;
          if (r_full > 35'sd2147483647) begin
            out_nxt.value = 32'sh7fffffff;
          end else if (r_full < -35'sd2147483648) begin
            out_nxt.value = 32'sh80000000;
          end else begin
            out_nxt.value = r_full[31:0];
          end
          state_nxt = stli_pkg::S_IDLE;
        end
      end
      default: state_nxt = stli_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stli_pkg::S_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r    <= j_nxt;
    qx_r   <= qx_nxt;
    last_r <= last_nxt;
    tx0_r  <= tx0_nxt;
    txl_r  <= txl_nxt;
    x1_r   <= x1_nxt;
    y1_r   <= y1_nxt;
    y0_r   <= y0_nxt;
    dy_r   <= dy_nxt;
    t_r    <= t_nxt;
    dx_r   <= dx_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
